[rtl/core/tmhq_pkg.sv]
// Package: request/result types and codes for the ternary min-heap queue.
package tmhq_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOWER  = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_ABSENT    = 3'd3;
  localparam logic [2:0] ST_NOT_LOWER = 3'd4;

  localparam int ID_W  = 8;
  localparam int ID_N  = 256;
  localparam int OKEY_W = 32;
  localparam int OCC_W = 9;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   element_id;
    logic [OKEY_W-1:0] new_key;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   removed_id;
    logic [OKEY_W-1:0] removed_key;
    logic [ID_W-1:0]   head_id;
    logic [OKEY_W-1:0] head_key;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
  } rsp_t;

endpackage

[rtl/core/tmhq_heap_mem.sv]
// Heap slot memory (key and id per slot) with a mirror of the root slot.
module tmhq_heap_mem #(
  parameter int SW = 8,
  parameter int KW = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [SW-1:0]            wr_addr,
  input  logic [KW-1:0]            wr_key,
  input  logic [tmhq_pkg::ID_W-1:0] wr_id,
  input  logic                     rd_en,
  input  logic [SW-1:0]            rd_addr,
  output logic [KW-1:0]            rd_key,
  output logic [tmhq_pkg::ID_W-1:0] rd_id,
  output logic [KW-1:0]            root_key,
  output logic [tmhq_pkg::ID_W-1:0] root_id
);
  import tmhq_pkg::*;

  logic [KW+ID_W-1:0] mem [2**SW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_id};
    end
    if (rd_en) begin
      {rd_key, rd_id} <= mem[rd_addr];
    end
    if (wr_en && wr_addr == '0) begin
      root_key <= wr_key;
      root_id  <= wr_id;
    end
  end

endmodule

[rtl/core/tmhq_pos_mem.sv]
// Position map memory: slot held by each element id.
module tmhq_pos_mem #(
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [tmhq_pkg::ID_W-1:0] wr_addr,
  input  logic [SW-1:0]             wr_slot,
  input  logic                      rd_en,
  input  logic [tmhq_pkg::ID_W-1:0] rd_addr,
  output logic [SW-1:0]             rd_slot
);
  import tmhq_pkg::*;

  logic [SW-1:0] mem [ID_N];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/ternary_min_heap_queue_core.sv]
// Top level: indexed ARITY-ary min-heap priority queue with decrease-key.
// A request is taken when start is high and busy is low; exactly one result
// follows on result, marked by a one-cycle done strobe that cannot be held
// off, so the receiver must take it in that cycle. An insert or a decrease-key
// raises the entry level by level (parent index, parent read, compare and write
// back per level); a removal lowers the entry level by level, reading the
// children of each level one at a time through the single read port of the
// slot memory.
// No clearing pass follows reset: presence flags and the count are flops.
module ternary_min_heap_queue_core #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32,
  parameter int ARITY     = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tmhq_pkg::req_t request,
  output logic           done,
  output tmhq_pkg::rsp_t result
);
  import tmhq_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (ARITY > 1) ? $clog2(ARITY) : 1;
  localparam int XW = CW + AW + 2;
  localparam int DS = SW + AW;
  localparam int PW = SW + DS + 1;
  localparam longint DM = ((64'd1 << DS) + ARITY - 1) / ARITY;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_KEY   = 4'd2;
  localparam logic [3:0] S_LAST  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_UPRD  = 4'd5;
  localparam logic [3:0] S_UPCMP = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_DNRD  = 4'd8;
  localparam logic [3:0] S_DNCMP = 4'd9;
  localparam logic [3:0] S_DNEND = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0]           state;
  logic [CW-1:0]        count;
  logic [ID_N-1:0]      present;

  logic [KEY_WIDTH-1:0] req_key;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [ID_W-1:0]      cur_id;
  logic [SW-1:0]        idx;
  logic [SW-1:0]        parent;
  logic [XW-1:0]        base;
  logic [AW-1:0]        cidx;
  logic                 found;
  logic [KEY_WIDTH-1:0] best_key;
  logic [ID_W-1:0]      best_id;
  logic [SW-1:0]        best_slot;
  logic [2:0]           status;
  logic [ID_W-1:0]      rem_id;
  logic [OKEY_W-1:0]    rem_key;

  logic                 h_we, h_re;
  logic [SW-1:0]        h_waddr, h_raddr;
  logic [KEY_WIDTH-1:0] h_wkey, h_rkey, root_key;
  logic [ID_W-1:0]      h_wid, h_rid, root_id;
  logic                 p_we, p_re;
  logic [ID_W-1:0]      p_waddr, p_raddr;
  logic [SW-1:0]        p_wslot, p_rslot;

  logic                 accept;
  logic [XW-1:0]        child;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        idx_m1;
  logic                 up_less;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign child   = base + XW'(cidx);
  assign idx_m1  = idx - SW'(1);
  assign prod    = PW'(idx_m1) * PW'(DM);
  assign up_less = (cur_key < h_rkey);
  assign req_key = KEY_WIDTH'(request.new_key);

  tmhq_heap_mem #(.SW(SW), .KW(KEY_WIDTH)) u_heap (
    .clk(clk), .wr_en(h_we), .wr_addr(h_waddr), .wr_key(h_wkey), .wr_id(h_wid),
    .rd_en(h_re), .rd_addr(h_raddr), .rd_key(h_rkey), .rd_id(h_rid),
    .root_key(root_key), .root_id(root_id)
  );

  tmhq_pos_mem #(.SW(SW)) u_pos (
    .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_slot(p_wslot),
    .rd_en(p_re), .rd_addr(p_raddr), .rd_slot(p_rslot)
  );

  always_comb begin
    h_we = 1'b0; h_waddr = idx; h_wkey = cur_key; h_wid = cur_id;
    h_re = 1'b0; h_raddr = '0;
    p_we = 1'b0; p_waddr = cur_id; p_wslot = idx;
    p_re = 1'b0; p_raddr = request.element_id;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((request.action == ACT_INSERT || request.action == ACT_LOWER) &&
              present[request.element_id]) begin
            p_re = 1'b1;
          end
          if (request.action == ACT_REMOVE && count > CW'(1)) begin
            h_re    = 1'b1;
            h_raddr = SW'(count - CW'(1));
          end
        end
      end
      S_POS: begin
        h_re    = 1'b1;
        h_raddr = p_rslot;
      end
      S_UP: begin
        if (idx == '0) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_UPRD: begin
        h_re    = 1'b1;
        h_raddr = parent;
      end
      S_UPCMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (up_less) begin
          h_wkey  = h_rkey;
          h_wid   = h_rid;
          p_waddr = h_rid;
        end
      end
      S_DNRD: begin
        h_re    = (child < XW'(count));
        h_raddr = SW'(child);
      end
      S_DNEND: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (found) begin
          h_wkey  = best_key;
          h_wid   = best_id;
          p_waddr = best_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      present <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_key <= req_key;
            cur_id  <= request.element_id;
            status  <= ST_OK;
            rem_id  <= '0;
            rem_key <= '0;
            state   <= S_RESP;
            unique case (request.action)
              ACT_INSERT, ACT_LOWER: begin
                if (present[request.element_id]) begin
                  state <= S_POS;
                end else if (request.action == ACT_LOWER) begin
                  status <= ST_ABSENT;
                end else if (count >= CW'(CAPACITY)) begin
                  status <= ST_FULL;
                end else begin
                  idx     <= SW'(count);
                  count   <= count + CW'(1);
                  present[request.element_id] <= 1'b1;
                  state   <= S_UP;
                end
              end
              ACT_REMOVE: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  rem_id  <= root_id;
                  rem_key <= OKEY_W'(root_key);
                  present[root_id] <= 1'b0;
                  count   <= count - CW'(1);
                  if (count > CW'(1)) begin
                    state <= S_LAST;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POS: begin
          idx   <= p_rslot;
          state <= S_KEY;
        end
        S_KEY: begin
          if (up_less) begin
            state <= S_UP;
          end else begin
            status <= ST_NOT_LOWER;
            state  <= S_RESP;
          end
        end
        S_LAST: begin
          cur_key <= h_rkey;
          cur_id  <= h_rid;
          idx     <= '0;
          state   <= S_DN;
        end
        S_UP: begin
          parent <= prod[DS +: SW];
          state  <= (idx == '0) ? S_RESP : S_UPRD;
        end
        S_UPRD: begin
          state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (up_less) begin
            idx   <= parent;
            state <= S_UP;
          end else begin
            state <= S_RESP;
          end
        end
        S_DN: begin
          base     <= XW'(idx) * XW'(ARITY) + XW'(1);
          cidx     <= '0;
          found    <= 1'b0;
          best_key <= cur_key;
          state    <= S_DNRD;
        end
        S_DNRD: begin
          state <= (child < XW'(count)) ? S_DNCMP : S_DNEND;
        end
        S_DNCMP: begin
          if (h_rkey < best_key) begin
            best_key  <= h_rkey;
            best_id   <= h_rid;
            best_slot <= SW'(child);
            found     <= 1'b1;
          end
          if (cidx == AW'(ARITY - 1)) begin
            state <= S_DNEND;
          end else begin
            cidx  <= cidx + AW'(1);
            state <= S_DNRD;
          end
        end
        S_DNEND: begin
          if (found) begin
            idx   <= best_slot;
            state <= S_DN;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done               = (state == S_RESP);
  assign result.status      = status;
  assign result.removed_id  = rem_id;
  assign result.removed_key = rem_key;
  assign result.head_id     = (count == '0) ? '0 : root_id;
  assign result.head_key    = (count == '0) ? '0 : OKEY_W'(root_key);
  assign result.occupancy   = OCC_W'(count);
  assign result.is_empty    = (count == '0);

endmodule

[rtl/core/tmhq_checker.sv]
// Checker on the ports of the heap queue top level, with its bind.
module tmhq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input tmhq_pkg::rsp_t result
);
  import tmhq_pkg::*;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside a request");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.head_id == '0 && result.head_key == '0))
    else $error("head shown on empty queue");

endmodule

bind ternary_min_heap_queue_core tmhq_checker u_tmhq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

[tb/tb_top.sv]
// Testbench: ternary min-heap queue core checked against an in-bench heap predictor.
module tb_top;
  import tmhq_pkg::*;

  localparam int CAP = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    req_t req;
    logic has_fixed;
    rsp_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t request = '0;
  rsp_t result;

  ternary_min_heap_queue_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] hp_key[CAP];
  logic [7:0]  hp_id[CAP];
  int          pos_of[ID_N];
  bit          present[ID_N];
  int          count;

  rsp_t expected_q[$];
  row_t rows[$];
  int   errors = 0;
  int   idle_cycles = 0;

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
  endtask

  function automatic void add_row(req_t r, logic has_fixed, rsp_t fixed);
    row_t w;
    w.req = r;
    w.has_fixed = has_fixed;
    w.fixed = fixed;
    rows.insert(rows.size(), w);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] k;
    logic [7:0] d;
    k = hp_key[a]; d = hp_id[a];
    hp_key[a] = hp_key[b]; hp_id[a] = hp_id[b];
    hp_key[b] = k; hp_id[b] = d;
    pos_of[hp_id[a]] = a;
    pos_of[hp_id[b]] = b;
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 3;
      if (!(hp_key[i] < hp_key[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sink(int i);
    int best;
    int ch;
    forever begin
      best = i;
      for (int c = 0; c < 3; c++) begin
        ch = 3 * i + 1 + c;
        if (ch < count && hp_key[ch] < hp_key[best]) best = ch;
      end
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic logic [2:0] lower(int id, logic [31:0] key);
    int s;
    s = pos_of[id];
    if (s >= count || !(key < hp_key[s])) return ST_NOT_LOWER;
    hp_key[s] = key;
    rise(s);
    return ST_OK;
  endfunction

  function automatic rsp_t heap_step(req_t r);
    rsp_t o;
    int id;
    o = '0;
    id = int'(r.element_id);
    case (r.action)
      ACT_INSERT: begin
        if (present[id]) o.status = lower(id, r.new_key);
        else if (count >= CAP) o.status = ST_FULL;
        else begin
          hp_key[count] = r.new_key;
          hp_id[count] = r.element_id;
          pos_of[id] = count;
          present[id] = 1'b1;
          count++;
          rise(count - 1);
        end
      end
      ACT_LOWER: begin
        if (!present[id]) o.status = ST_ABSENT;
        else o.status = lower(id, r.new_key);
      end
      ACT_REMOVE: begin
        if (count == 0) o.status = ST_EMPTY;
        else begin
          o.removed_id = hp_id[0];
          o.removed_key = hp_key[0];
          present[hp_id[0]] = 1'b0;
          count--;
          if (count > 0) begin
            hp_key[0] = hp_key[count];
            hp_id[0] = hp_id[count];
            pos_of[hp_id[0]] = 0;
            sink(0);
          end
        end
      end
      default: o.status = ST_OK;
    endcase
    o.head_id = count ? hp_id[0] : '0;
    o.head_key = count ? hp_key[0] : '0;
    o.occupancy = OCC_W'(count);
    o.is_empty = (count == 0);
    return o;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("** ternary_min_heap_queue_core: FAILED **");
        $finish;
      end
      if (done) begin
        if (expected_q.size() == 0) report("unexpected result", 128'(result), 128'(0));
        else begin
          e = expected_q.pop_front();
          if (result.status !== e.status)
            report("status", 128'(result.status), 128'(e.status));
          if (result.removed_id !== e.removed_id)
            report("removed_id", 128'(result.removed_id), 128'(e.removed_id));
          if (result.removed_key !== e.removed_key)
            report("removed_key", 128'(result.removed_key), 128'(e.removed_key));
          if (result.head_id !== e.head_id)
            report("head_id", 128'(result.head_id), 128'(e.head_id));
          if (result.head_key !== e.head_key)
            report("head_key", 128'(result.head_key), 128'(e.head_key));
          if (result.occupancy !== e.occupancy)
            report("occupancy", 128'(result.occupancy), 128'(e.occupancy));
          if (result.is_empty !== e.is_empty)
            report("is_empty", 128'(result.is_empty), 128'(e.is_empty));
        end
      end
    end
  end

  task automatic send(input req_t r, input logic has_fixed, input rsp_t fixed);
    rsp_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    p = heap_step(r);
    if (has_fixed && p !== fixed) report("predictor row", 128'(p), 128'(fixed));
    expected_q.insert(expected_q.size(), p);
  endtask

  function automatic req_t mk(logic [1:0] a, logic [7:0] id, logic [31:0] k);
    req_t r;
    r.action = a; r.element_id = id; r.new_key = k;
    return r;
  endfunction

  function automatic rsp_t fx(logic [2:0] st, logic [7:0] rid, logic [31:0] rk,
                              logic [7:0] hid, logic [31:0] hk, int occ);
    rsp_t o;
    o.status = st; o.removed_id = rid; o.removed_key = rk;
    o.head_id = hid; o.head_key = hk; o.occupancy = OCC_W'(occ); o.is_empty = (occ == 0);
    return o;
  endfunction

  // pick an id, mostly present ones for updates
  function automatic logic [7:0] pick_id(bit want_present, int span);
    int tries;
    logic [7:0] id;
    for (tries = 0; tries < 20; tries++) begin
      id = 8'($urandom_range(0, span));
      if (present[id] == want_present) return id;
    end
    return id;
  endfunction

  initial begin
    req_t r;
    int n;
    int span;
    int sel;
    logic [31:0] k;

    count = 0;
    foreach (present[i]) present[i] = 1'b0;

    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b1, fx(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(mk(ACT_LOWER, 8'h05, 32'h1), 1'b1, fx(ST_ABSENT, 0, 0, 0, 0, 0));
    add_row(mk(2'd3, 8'hFF, 32'hFFFFFFFF), 1'b1, fx(ST_OK, 0, 0, 0, 0, 0));
    add_row(mk(ACT_INSERT, 8'hFF, 32'hFFFFFFFF), 1'b1,
            fx(ST_OK, 0, 0, 8'hFF, 32'hFFFFFFFF, 1));
    add_row(mk(ACT_INSERT, 8'h00, 32'h0), 1'b1, fx(ST_OK, 0, 0, 8'h00, 32'h0, 2));
    add_row(mk(ACT_INSERT, 8'h10, 32'h0), 1'b1, fx(ST_OK, 0, 0, 8'h00, 32'h0, 3));
    add_row(mk(ACT_LOWER, 8'h10, 32'h0), 1'b1,
            fx(ST_NOT_LOWER, 0, 0, 8'h00, 32'h0, 3));
    add_row(mk(ACT_INSERT, 8'hFF, 32'hFFFFFFFF), 1'b1,
            fx(ST_NOT_LOWER, 0, 0, 8'h00, 32'h0, 3));
    add_row(mk(ACT_INSERT, 8'h55, 32'h5555AAAA), 1'b0, '0);
    add_row(mk(ACT_INSERT, 8'hAA, 32'hAAAA5555), 1'b0, '0);
    add_row(mk(ACT_INSERT, 8'hFF, 32'h00000000), 1'b0, '0);
    add_row(mk(ACT_LOWER, 8'hAA, 32'h00000001), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'hFF, 32'hFFFFFFFF), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b0, '0);
    add_row(mk(ACT_REMOVE, 8'h00, 32'h0), 1'b1, fx(ST_EMPTY, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].req, rows[i].has_fixed, rows[i].fixed);

    // fill to capacity, re-insert a present id, then lowers, then drain
    for (int i = 0; i < CAP; i++) send(mk(ACT_INSERT, 8'(i), $urandom), 1'b0, '0);
    send(mk(ACT_INSERT, 8'h00, 32'hFFFFFFFF), 1'b0, '0);
    for (int i = 0; i < 6; i++) send(mk(ACT_LOWER, 8'($urandom), $urandom), 1'b0, '0);
    for (int i = 0; i < 300; i++) send(mk(ACT_REMOVE, 8'($urandom), $urandom), 1'b0, '0);

    // random phases with varying id span and key range
    n = 0;
    while (n < 700) begin
      span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(3, 40);
      repeat ($urandom_range(20, 60)) begin
        sel = $urandom_range(0, 99);
        k = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 15);
        if (sel < 45) r = mk(ACT_INSERT, pick_id(1'b0, span), k);
        else if (sel < 70) r = mk(ACT_LOWER, pick_id(1'b1, span), k >> $urandom_range(0, 31));
        else if (sel < 97) r = mk(ACT_REMOVE, 8'($urandom), $urandom);
        else r = mk(2'd3, 8'($urandom), $urandom);
        send(r, 1'b0, '0);
        n++;
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** ternary_min_heap_queue_core: PASSED **");
    end else begin
      $display("** ternary_min_heap_queue_core: FAILED **");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/tmhq_pkg.sv
rtl/core/tmhq_heap_mem.sv
rtl/core/tmhq_pos_mem.sv
rtl/core/ternary_min_heap_queue_core.sv
rtl/core/tmhq_checker.sv
tb/tb_top.sv
